// File: design/tlv_container_parser_macros.svh
// assertion macros used by the tlv container parser core
`ifndef TLV_CONTAINER_PARSER_MACROS_SVH
`define TLV_CONTAINER_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TLVCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlvcp assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TLVCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlvcp assertion failed");

`endif

// File: design/tlvcp_pkg.sv
// shared types and constants for the tlv container parser
package tlvcp_pkg;

    // width of container lengths, byte positions and announced value lengths
    localparam int LENGTH_BITS = 24;

    // smallest container that may carry the single empty-type value
    localparam logic [LENGTH_BITS-1:0] BIG_MIN = LENGTH_BITS'(32'h0001_0002);

    // result kinds
    localparam logic [2:0] KIND_TYPE_BYTE  = 3'd0;
    localparam logic [2:0] KIND_TYPE_END   = 3'd1;
    localparam logic [2:0] KIND_VALUE_LEN  = 3'd2;
    localparam logic [2:0] KIND_VALUE_BYTE = 3'd3;
    localparam logic [2:0] KIND_END_MARK   = 3'd4;

    // one input transaction
    typedef struct packed {
        logic [7:0]             data_byte;
        logic [LENGTH_BITS-1:0] container_length;
    } tlvcp_item_t;

    // one result transaction
    typedef struct packed {
        logic [2:0]             kind;
        logic [7:0]             out_byte;
        logic [LENGTH_BITS-1:0] value_length;
        logic                   record_end;
        logic                   container_end;
        logic                   error;
    } tlvcp_result_t;

endpackage

// File: design/tlvcp_ifs.sv
// valid/ready channel interfaces for the tlv container parser

// input byte channel
interface tlvcp_in_if;
    import tlvcp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [7:0]             data_byte;
    logic [LENGTH_BITS-1:0] container_length;

    modport source (output valid, output data_byte, output container_length, input ready);
    modport sink   (input valid, input data_byte, input container_length, output ready);
endinterface

// result event channel
interface tlvcp_out_if;
    import tlvcp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [2:0]             kind;
    logic [7:0]             out_byte;
    logic [LENGTH_BITS-1:0] value_length;
    logic                   record_end;
    logic                   container_end;
    logic                   error;

    modport source (output valid, output kind, output out_byte, output value_length,
                    output record_end, output container_end, output error, input ready);
    modport sink   (input valid, input kind, input out_byte, input value_length,
                    input record_end, input container_end, input error, output ready);
endinterface

// File: design/tlv_container_parser.sv
// top level of the tlv container parser
// Byte-serial TLV container parser. One byte transaction is accepted per clock cycle,
// back to back, for as long as the result side keeps up; each byte gives at most one
// event transaction, presented on the result side after acceptance through the input
// register and then the parser step into the result register. Throughput is set by
// the phase and position update in the parser core.
// Length-high bytes and byte 1 of a large empty-type container give no event unless
// they close the container. Stalls on the result side hold the pipeline without loss.
module tlv_container_parser (
    input  logic        clk,
    input  logic        rst_n,
    tlvcp_in_if.sink    in_chan,
    tlvcp_out_if.source out_chan
);
    import tlvcp_pkg::*;

    tlvcp_item_t   in_item;
    tlvcp_item_t   item;
    logic          item_valid;
    logic          item_ready;
    tlvcp_result_t result;

    assign in_item.data_byte        = in_chan.data_byte;
    assign in_item.container_length = in_chan.container_length;

    // input register
    tlvcp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_chan.valid),
        .in_ready   (in_chan.ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // parser step and result register
    tlvcp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (out_chan.valid),
        .result_ready (out_chan.ready),
        .result       (result)
    );

    assign out_chan.kind          = result.kind;
    assign out_chan.out_byte      = result.out_byte;
    assign out_chan.value_length  = result.value_length;
    assign out_chan.record_end    = result.record_end;
    assign out_chan.container_end = result.container_end;
    assign out_chan.error         = result.error;

endmodule

// File: design/tlvcp_in_stage.sv
// input register stage: captures one byte transaction per cycle while the core accepts
module tlvcp_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tlvcp_pkg::tlvcp_item_t in_item,
    output logic                  item_valid,
    input  logic                  item_ready,
    output tlvcp_pkg::tlvcp_item_t item
);
    import tlvcp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    tlvcp_item_t item_reg;
    logic        in_fire;

    // accept when empty or when the held transaction moves on this cycle
    assign in_ready = !valid_reg || item_ready;
    assign in_fire  = in_valid && in_ready;

    // occupancy
    always_comb
    begin
        if (in_fire)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: design/tlvcp_core.sv
// parser state machine and result register
`include "tlv_container_parser_macros.svh"

module tlvcp_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  tlvcp_pkg::tlvcp_item_t  item,
    output logic                    result_valid,
    input  logic                    result_ready,
    output tlvcp_pkg::tlvcp_result_t result
);
    import tlvcp_pkg::*;

    // parser phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_TYPE   = 3'd1;
    localparam logic [2:0] PH_LENHI  = 3'd2;
    localparam logic [2:0] PH_LENLO  = 3'd3;
    localparam logic [2:0] PH_VALUE  = 3'd4;
    localparam logic [2:0] PH_BIGLEN = 3'd5;
    localparam logic [2:0] PH_BIGVAL = 3'd6;

    localparam logic [LENGTH_BITS-1:0] POS_TWO   = LENGTH_BITS'(2);
    localparam logic [LENGTH_BITS-1:0] LEN_THREE = LENGTH_BITS'(3);

    logic [2:0]             phase_reg, phase_next;
    logic [7:0]             length_high_reg, length_high_next;
    logic [LENGTH_BITS-1:0] bytes_remaining_reg, bytes_remaining_next;
    logic [LENGTH_BITS-1:0] byte_position_reg, byte_position_next;
    logic                   out_valid_reg, out_valid_next;
    tlvcp_result_t          result_reg, result_next;

    logic                   fire;
    logic                   last;
    logic                   have;
    logic                   big_start;
    logic [LENGTH_BITS:0]   pos_inc;
    logic [15:0]            announced;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [7:0]             b;
    logic [LENGTH_BITS-1:0] cl;

    assign item_ready = !out_valid_reg || result_ready;
    assign fire       = item_valid && item_ready;

    assign b         = item.data_byte;
    assign cl        = item.container_length;
    assign pos_inc   = {1'b0, byte_position_reg} + {{LENGTH_BITS{1'b0}}, 1'b1};
    assign last      = pos_inc >= {1'b0, cl};
    assign big_start = (byte_position_reg == '0) && (cl >= BIG_MIN) && (b == 8'd0);
    assign announced = {length_high_reg, b};
    assign rem_dec   = bytes_remaining_reg - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

    // per-byte step: phase update and event selection
    always_comb
    begin
        phase_next           = phase_reg;
        length_high_next     = length_high_reg;
        bytes_remaining_next = bytes_remaining_reg;
        byte_position_next   = pos_inc[LENGTH_BITS-1:0];
        have                 = 1'b1;
        result_next          = '0;
        result_next.kind     = KIND_END_MARK;

        if (big_start)
        begin
            result_next.kind = KIND_TYPE_END;
            phase_next       = PH_BIGLEN;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE, PH_TYPE:
                begin
                    if (b == 8'd0)
                    begin
                        result_next.kind = KIND_TYPE_END;
                        phase_next       = PH_LENHI;
                    end
                    else
                    begin
                        result_next.kind     = KIND_TYPE_BYTE;
                        result_next.out_byte = b;
                        phase_next           = PH_TYPE;
                    end
                end
                PH_LENHI:
                begin
                    length_high_next = b;
                    phase_next       = PH_LENLO;
                    have             = 1'b0;
                end
                PH_LENLO:
                begin
                    result_next.kind         = KIND_VALUE_LEN;
                    result_next.value_length = LENGTH_BITS'(announced);
                    if (announced == 16'd0)
                    begin
                        result_next.record_end = 1'b1;
                        phase_next             = PH_IDLE;
                    end
                    else
                    begin
                        bytes_remaining_next = LENGTH_BITS'(announced);
                        phase_next           = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    result_next.kind     = KIND_VALUE_BYTE;
                    result_next.out_byte = b;
                    bytes_remaining_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        result_next.record_end = 1'b1;
                        phase_next             = PH_IDLE;
                    end
                end
                PH_BIGLEN:
                begin
                    if (byte_position_reg >= POS_TWO)
                    begin
                        result_next.kind         = KIND_VALUE_LEN;
                        result_next.value_length = (cl > LEN_THREE) ? (cl - LEN_THREE) : '0;
                        phase_next               = PH_BIGVAL;
                    end
                    else
                    begin
                        have = 1'b0;
                    end
                end
                PH_BIGVAL:
                begin
                    result_next.kind     = KIND_VALUE_BYTE;
                    result_next.out_byte = b;
                    if (last)
                    begin
                        result_next.record_end = 1'b1;
                        phase_next             = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    have       = 1'b0;
                end
            endcase
        end

        // final byte: close the container and return to reset state
        if (last)
        begin
            result_next.container_end = 1'b1;
            result_next.error         = (phase_next != PH_IDLE);
            if (!have)
            begin
                result_next.kind         = KIND_END_MARK;
                result_next.out_byte     = 8'd0;
                result_next.value_length = '0;
                result_next.record_end   = 1'b0;
            end
            phase_next           = PH_IDLE;
            length_high_next     = 8'd0;
            bytes_remaining_next = '0;
            byte_position_next   = '0;
        end
    end

    // result occupancy
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = have || last;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            length_high_reg     <= 8'd0;
            bytes_remaining_reg <= '0;
            byte_position_reg   <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg           <= phase_next;
                length_high_reg     <= length_high_next;
                bytes_remaining_reg <= bytes_remaining_next;
                byte_position_reg   <= byte_position_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire && (have || last))
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // checks
    `TLVCP_ASSERT_NOW(a_error_on_final, clk, rst_n, out_valid_reg && result_reg.error,
        result_reg.container_end)
    `TLVCP_ASSERT_NOW(a_len_only_kind2, clk, rst_n,
        out_valid_reg && (result_reg.kind != KIND_VALUE_LEN), result_reg.value_length == '0)
    `TLVCP_ASSERT_NEXT(a_final_resets, clk, rst_n, fire && last,
        (byte_position_reg == '0) && (phase_reg == PH_IDLE) && (bytes_remaining_reg == '0))
    `TLVCP_ASSERT_NOW(a_value_has_count, clk, rst_n, phase_reg == PH_VALUE,
        bytes_remaining_reg != '0)

endmodule

// File: tb/sv/tlvcp_event_checker.sv
`timescale 1ns / 1ps
// event checker for the tlv container parser: mirrors the parse state and compares events
module tlvcp_event_checker
    import tlvcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tlvcp_in_if  in_mon,
    tlvcp_out_if out_mon,
    output int   fail_count,
    output int   pending,
    output int   event_count,
    output int   container_count,
    output int   broken_count
);

    // where the mirror stands inside the current record
    localparam logic [2:0] ST_START     = 3'd0;
    localparam logic [2:0] ST_TYPE      = 3'd1;
    localparam logic [2:0] ST_LEN_HI    = 3'd2;
    localparam logic [2:0] ST_LEN_LO    = 3'd3;
    localparam logic [2:0] ST_VALUE     = 3'd4;
    localparam logic [2:0] ST_BIG_HDR   = 3'd5;
    localparam logic [2:0] ST_BIG_VALUE = 3'd6;

    logic [2:0]             cur_state;
    logic [7:0]             len_high;
    logic [LENGTH_BITS-1:0] value_left;
    logic [LENGTH_BITS-1:0] byte_pos;

    tlvcp_result_t          expected_events[$];
    tlvcp_result_t          head_event;
    tlvcp_result_t          new_event;

    // advance the mirror by one byte; returns 1 when the byte yields an event
    function automatic bit parse_byte(input logic [7:0] b,
                                      input logic [LENGTH_BITS-1:0] clen,
                                      output tlvcp_result_t ev);
        logic [LENGTH_BITS:0]   next_pos;
        logic                   is_last;
        bit                     have;
        logic [2:0]             kind;
        logic [7:0]             ob;
        logic [LENGTH_BITS-1:0] vlen;
        logic                   rend;

        next_pos = {1'b0, byte_pos} + (LENGTH_BITS+1)'(1);
        is_last  = next_pos >= {1'b0, clen};
        have     = 1'b1;
        kind     = KIND_END_MARK;
        ob       = '0;
        vlen     = '0;
        rend     = 1'b0;

        // large container opening with a zero byte: one value of the empty type
        if (byte_pos == '0 && clen >= BIG_MIN && b == 8'h00)
        begin
            kind      = KIND_TYPE_END;
            cur_state = ST_BIG_HDR;
        end
        else
        begin
            case (cur_state)
                ST_START, ST_TYPE:
                begin
                    if (b == 8'h00)
                    begin
                        kind      = KIND_TYPE_END;
                        cur_state = ST_LEN_HI;
                    end
                    else
                    begin
                        kind      = KIND_TYPE_BYTE;
                        ob        = b;
                        cur_state = ST_TYPE;
                    end
                end
                ST_LEN_HI:
                begin
                    len_high  = b;
                    cur_state = ST_LEN_LO;
                    have      = 1'b0;
                end
                ST_LEN_LO:
                begin
                    kind = KIND_VALUE_LEN;
                    vlen = LENGTH_BITS'({len_high, b});
                    if (vlen == '0)
                    begin
                        rend      = 1'b1;
                        cur_state = ST_START;
                    end
                    else
                    begin
                        value_left = vlen;
                        cur_state  = ST_VALUE;
                    end
                end
                ST_VALUE:
                begin
                    kind       = KIND_VALUE_BYTE;
                    ob         = b;
                    value_left = value_left - LENGTH_BITS'(1);
                    if (value_left == '0)
                    begin
                        rend      = 1'b1;
                        cur_state = ST_START;
                    end
                end
                ST_BIG_HDR:
                begin
                    // byte 1 is skipped, byte 2 announces the rest
                    if (byte_pos >= LENGTH_BITS'(2))
                    begin
                        kind      = KIND_VALUE_LEN;
                        vlen      = (clen > LENGTH_BITS'(3)) ? clen - LENGTH_BITS'(3) : '0;
                        cur_state = ST_BIG_VALUE;
                    end
                    else
                    begin
                        have = 1'b0;
                    end
                end
                ST_BIG_VALUE:
                begin
                    kind = KIND_VALUE_BYTE;
                    ob   = b;
                    if (is_last)
                    begin
                        rend      = 1'b1;
                        cur_state = ST_START;
                    end
                end
                default:
                begin
                    cur_state = ST_START;
                    have      = 1'b0;
                end
            endcase
        end

        // a silent byte that closes the container becomes a bare end marker
        if (!have)
        begin
            kind = KIND_END_MARK;
            ob   = '0;
            vlen = '0;
            rend = 1'b0;
        end

        ev.kind          = kind;
        ev.out_byte      = ob;
        ev.value_length  = vlen;
        ev.record_end    = rend;
        ev.container_end = is_last;
        ev.error         = is_last && (cur_state != ST_START);

        if (is_last)
        begin
            cur_state  = ST_START;
            len_high   = '0;
            value_left = '0;
            byte_pos   = '0;
        end
        else
        begin
            byte_pos = next_pos[LENGTH_BITS-1:0];
        end
        return have || is_last;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // compare finished events, then predict from accepted bytes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state  = ST_START;
            len_high   = '0;
            value_left = '0;
            byte_pos   = '0;
            expected_events.delete();
            pending    = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                event_count++;
                if (out_mon.container_end)
                    container_count++;
                if (out_mon.error)
                    broken_count++;
                if (expected_events.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected event, expected none, got kind %0d byte %0h len %0h",
                             $time, out_mon.kind, out_mon.out_byte, out_mon.value_length);
                end
                else
                begin
                    head_event = expected_events.pop_front();
                    report_field("kind", 32'(head_event.kind), 32'(out_mon.kind));
                    report_field("out_byte", 32'(head_event.out_byte), 32'(out_mon.out_byte));
                    report_field("value_length", 32'(head_event.value_length),
                                 32'(out_mon.value_length));
                    report_field("record_end", 32'(head_event.record_end),
                                 32'(out_mon.record_end));
                    report_field("container_end", 32'(head_event.container_end),
                                 32'(out_mon.container_end));
                    report_field("error", 32'(head_event.error), 32'(out_mon.error));
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                if (parse_byte(in_mon.data_byte, in_mon.container_length, new_event))
                    expected_events = {expected_events, new_event};
            end
            pending = expected_events.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the tlv container parser: clock, reset, container stimulus and verdict
module tb_top;
    import tlvcp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int TAIL_BYTES     = 64;
    localparam int DRAIN_CYCLES   = 8;

    // directed transactions, each {data_byte, container_length}
    localparam logic [31:0] DIRECTED_ITEMS [25] = '{
        // lone terminator closes the container with the record open
        32'h00_000001,
        // zero container length closes on every byte
        32'hFF_000000,
        // extreme type bytes with an empty value
        32'h01_000005, 32'hFF_000005, 32'h00_000005, 32'h00_000005, 32'h00_000005,
        // two value bytes with alternating bits
        32'h80_000006, 32'h00_000006, 32'h00_000006, 32'h02_000006, 32'hAA_000006,
        32'h55_000006,
        // container ends on the length high byte
        32'h7F_000003, 32'h00_000003, 32'hFF_000003,
        // large container cut after byte 1
        32'h00_010002, 32'hFF_000002,
        // large header at the top length, then cut inside the value
        32'h00_FFFFFF, 32'h12_FFFFFF, 32'h34_FFFFFF, 32'h56_000004,
        // large header announcing an empty value while the container ends
        32'h00_010002, 32'h00_010002, 32'h00_000003
    };

    logic clk = 1'b0;
    logic rst_n;

    tlvcp_in_if  in_chan ();
    tlvcp_out_if out_chan ();

    int fail_count;
    int pending;
    int event_count;
    int container_count;
    int broken_count;

    logic [LENGTH_BITS-1:0] feed_pos;
    logic                   container_closed;
    bit                     quiet;
    bit                     sender_gaps;
    int                     items_sent;
    int                     idle_cycles;

    wire moved = (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready);

    tlv_container_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    tlvcp_event_checker event_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_mon          (in_chan),
        .out_mon         (out_chan),
        .fail_count      (fail_count),
        .pending         (pending),
        .event_count     (event_count),
        .container_count (container_count),
        .broken_count    (broken_count)
    );

    always #5 clk = ~clk;

    // one byte transaction, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic [LENGTH_BITS-1:0] clen);
        logic [LENGTH_BITS:0] next_pos;

        if (!quiet && sender_gaps && $urandom_range(0, 5) == 0)
        begin
            in_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_chan.valid            <= 1'b1;
        in_chan.data_byte        <= b;
        in_chan.container_length <= clen;
        do
            @(posedge clk);
        while (!in_chan.ready);
        // track where the parser will stand so containers stay aligned
        next_pos         = {1'b0, feed_pos} + (LENGTH_BITS+1)'(1);
        container_closed = next_pos >= {1'b0, clen};
        feed_pos         = container_closed ? '0 : next_pos[LENGTH_BITS-1:0];
        items_sent++;
    endtask

    // send a container; some lengths may be scrambled, which can close it early
    task automatic send_container(input logic [7:0] bytes_q[$], input int mutate_pct);
        int                     n;
        logic [LENGTH_BITS-1:0] clen;

        n = bytes_q.size();
        for (int i = 0; i < n; i++)
        begin
            clen = LENGTH_BITS'(n);
            if (i < n - 1 && $urandom_range(0, 99) < mutate_pct)
                clen = $urandom_range(0, 1) ? LENGTH_BITS'($urandom())
                                            : LENGTH_BITS'($urandom_range(0, 8));
            send_byte(bytes_q[i], clen);
            if (container_closed)
                break;
        end
    endtask

    // result side: random stall bursts and calm stretches
    initial
    begin
        out_chan.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_chan.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 49) == 0)
            begin
                out_chan.ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            out_chan.ready <= 1'b1;
        end
    end

    // watchdog on transactions in either direction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (moved)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [7:0] cbytes[$];
        int         nrec;
        int         tlen;
        int         vlen;
        int         style;

        rst_n                    <= 1'b0;
        in_chan.valid            <= 1'b0;
        in_chan.data_byte        <= '0;
        in_chan.container_length <= '0;
        quiet       = 1'b0;
        sender_gaps = 1'b1;
        feed_pos    = '0;
        items_sent  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases
        foreach (DIRECTED_ITEMS[i])
            send_byte(DIRECTED_ITEMS[i][31:24], DIRECTED_ITEMS[i][23:0]);

        // random containers: mostly well formed, some cut short or scrambled
        while (items_sent < RANDOM_ITEMS)
        begin
            cbytes.delete();
            style = $urandom_range(0, 9);
            if (style == 0)
            begin
                // raw noise
                repeat ($urandom_range(1, 12)) cbytes = {cbytes, 8'($urandom_range(0, 255))};
            end
            else
            begin
                nrec = $urandom_range(1, 3);
                repeat (nrec)
                begin
                    tlen = $urandom_range(0, 4);
                    repeat (tlen) cbytes = {cbytes, 8'($urandom_range(1, 255))};
                    cbytes = {cbytes, 8'h00};
                    if ($urandom_range(0, 49) == 0)
                        vlen = $urandom_range(256, 300);
                    else if ($urandom_range(0, 9) == 0)
                        vlen = $urandom_range(9, 40);
                    else
                        vlen = $urandom_range(0, 8);
                    cbytes = {cbytes, vlen[15:8]};
                    cbytes = {cbytes, vlen[7:0]};
                    repeat (vlen) cbytes = {cbytes, 8'($urandom_range(0, 255))};
                end
                // broken container: cut inside a record
                if (style == 1)
                    cbytes = cbytes[0:$urandom_range(0, cbytes.size() - 1)];
            end
            sender_gaps = $urandom_range(0, 2) != 0;
            send_container(cbytes, (style == 2) ? 20 : 0);
        end

        // large empty-type container whose length shrinks to close it inside the value,
        // no idling from here on
        quiet = 1'b1;
        send_byte(8'h00, BIG_MIN);
        for (int i = 1; i < TAIL_BYTES - 1; i++)
            send_byte(8'($urandom_range(0, 255)), BIG_MIN);
        send_byte(8'($urandom_range(0, 255)), LENGTH_BITS'(TAIL_BYTES));
        in_chan.valid <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input bytes, %0d events, %0d closed containers",
                 items_sent, event_count, container_count);
        $display("%0d containers ended inside a record, %0d mismatches",
                 broken_count, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/tlvcp_pkg.sv
design/tlvcp_ifs.sv
design/tlvcp_in_stage.sv
design/tlvcp_core.sv
design/tlv_container_parser.sv
tb/sv/tlvcp_event_checker.sv
tb/sv/tb_top.sv
